/* src/rse_pkg.sv */
// Package: shared constants, token and status codes, and types for the RPN evaluator.
`default_nettype none

package rse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 3;

    // divider retires this many quotient bits per cycle
    localparam int DIV_BITS    = 2;
    localparam int DIV_STEPS   = DATA_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [DATA_W-1:0]   t_data;
    typedef logic [CNT_W-1:0]    t_count;

    localparam t_func FN_NUM = 3'd0;
    localparam t_func FN_ADD = 3'd1;
    localparam t_func FN_SUB = 3'd2;
    localparam t_func FN_MUL = 3'd3;
    localparam t_func FN_DIV = 3'd4;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_INVALID  = 3'd1;
    localparam t_status ST_EMPTY    = 3'd2;
    localparam t_status ST_DIVZERO  = 3'd3;
    localparam t_status ST_OVERFLOW = 3'd4;

    // per-cell shift control: take the value above (push) or below (pop)
    typedef struct packed {
        logic load_prev;
        logic load_next;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* src/rse_ifs.sv */
// Interfaces: token input channel and result output channel.
`default_nettype none

interface rse_tok_if;
    import rse_pkg::*;

    logic               valid;
    logic               ready;
    t_func              func;
    logic signed [31:0] operand_value;
    logic               last_token;

    modport source (output valid, output func, output operand_value, output last_token,
                    input ready);
    modport sink   (input valid, input func, input operand_value, input last_token,
                    output ready);
endinterface

interface rse_res_if;
    import rse_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [31:0] answer;
    t_status            status;

    modport source (output valid, output answer, output status, input ready);
    modport sink   (input valid, input answer, input status, output ready);
endinterface

`default_nettype wire

/* src/rse_cell.sv */
// Stack cell: one operand entry, loads from the neighbor above or below.
`default_nettype none

module rse_cell (
    input  wire logic              i_clk,
    input  wire rse_pkg::t_cell_ctl i_ctl,
    input  wire rse_pkg::t_data    i_prev,
    input  wire rse_pkg::t_data    i_next,
    output      rse_pkg::t_data    o_val
);
    import rse_pkg::*;

    t_data r_val;
    t_data n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.load_prev) begin
            n_val = i_prev;
        end else if (i_ctl.load_next) begin
            n_val = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

/* src/rse_divider.sv */
// Signed divider: restoring, DIV_BITS quotient bits per cycle, truncates toward zero.
`default_nettype none

module rse_divider (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire rse_pkg::t_data i_dividend,
    input  wire rse_pkg::t_data i_divisor,
    output      logic           o_done,
    output      rse_pkg::t_data o_quotient
);
    import rse_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W:0]      r_rem;
    t_data                r_quo;
    t_data                r_div;
    logic                 r_neg;

    logic [DATA_W:0]      n_rem;
    t_data                n_quo;
    t_data                w_mag_a;
    t_data                w_mag_b;

    assign w_mag_a = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_mag_b = i_divisor[DATA_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;

    always_comb begin
        logic [DATA_W:0] v_rem;
        t_data           v_quo;
        v_rem = r_rem;
        v_quo = r_quo;
        for (int k = 0; k < DIV_BITS; k++) begin
            v_rem = {v_rem[DATA_W-1:0], v_quo[DATA_W-1]};
            v_quo = {v_quo[DATA_W-2:0], 1'b0};
            if (v_rem >= {1'b0, r_div}) begin
                v_rem    = v_rem - {1'b0, r_div};
                v_quo[0] = 1'b1;
            end
        end
        n_rem = v_rem;
        n_quo = v_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= w_mag_a;
            r_div <= w_mag_b;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    // most negative over minus one wraps back to itself here
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

`default_nettype wire

/* src/rpn_stack_evaluator.sv */
// Top level: RPN token sequencer over a shifting row of stack cells.
// Each token runs IDLE, EXEC, then FIN; add/sub/mul pass through WB, and divide
// waits in DIV, then WB (the divider retires two quotient bits per cycle).
// One token is in flight at a time; a finished result waits in the output
// register while the next token is taken. Reset (synchronous, active low)
// empties the stack and clears the error; cell contents are not cleared.
`default_nettype none

module rpn_stack_evaluator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rse_tok_if.sink    i_tok,
    rse_res_if.source  o_res
);
    import rse_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_count     r_cnt;
    t_count     n_cnt;
    t_status    r_err;
    t_status    n_err;
    t_func      r_func;
    t_data      r_val;
    logic       r_last;
    t_data      r_res;
    t_data      n_res;
    logic       r_out_valid;
    logic       n_out_valid;
    t_data      r_answer;
    t_data      n_answer;
    t_status    r_status;
    t_status    n_status;

    t_data      w_cell [STACK_DEPTH];
    t_cell_ctl  w_ctl  [STACK_DEPTH];
    t_data      w_push_data;
    logic       w_push;
    logic       w_wb;
    t_data      w_lhs;
    t_data      w_rhs;
    t_data      w_prod;
    logic       w_div_start;
    logic       w_div_done;
    t_data      w_quot;
    logic       w_accept;

    assign i_tok.ready = (r_state == S_IDLE);
    assign w_accept    = i_tok.valid && i_tok.ready;

    // popping an empty stack gives zero
    assign w_rhs  = (r_cnt != '0) ? w_cell[0] : '0;
    assign w_lhs  = (r_cnt > CNT_W'(1)) ? w_cell[1] : '0;
    assign w_prod = w_lhs * w_rhs;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_res.ready;
        n_answer    = r_answer;
        n_status    = r_status;
        w_push      = 1'b0;
        w_wb        = 1'b0;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                if (r_err == ST_OK) begin
                    case (r_func)
                        FN_NUM: begin
                            if (r_cnt < CNT_W'(STACK_DEPTH)) begin
                                w_push = 1'b1;
                                n_cnt  = r_cnt + 1'b1;
                            end else begin
                                n_err = ST_OVERFLOW;
                            end
                        end
                        FN_ADD: begin
                            n_res   = w_lhs + w_rhs;
                            n_state = S_WB;
                        end
                        FN_SUB: begin
                            n_res   = w_lhs - w_rhs;
                            n_state = S_WB;
                        end
                        FN_MUL: begin
                            n_res   = w_prod;
                            n_state = S_WB;
                        end
                        FN_DIV: begin
                            if (w_rhs == '0) begin
                                n_err = ST_DIVZERO;
                            end else begin
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                        default: begin
                            n_err = ST_INVALID;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res   = w_quot;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                // two pops and one push: net one entry fewer, at least one left
                w_wb    = 1'b1;
                n_cnt   = (r_cnt > CNT_W'(1)) ? (r_cnt - 1'b1) : CNT_W'(1);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    if (r_err != ST_OK) begin
                        n_status = r_err;
                        n_answer = '0;
                    end else if (r_cnt == '0) begin
                        n_status = ST_EMPTY;
                        n_answer = '0;
                    end else begin
                        n_status = ST_OK;
                        n_answer = w_cell[0];
                    end
                    n_cnt   = '0;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_push_data = w_wb ? r_res : r_val;

    always_comb begin
        for (int c = 0; c < STACK_DEPTH; c++) begin
            w_ctl[c].load_prev = w_push || (w_wb && (c == 0));
            w_ctl[c].load_next = w_wb && (c != 0);
        end
    end

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_data w_prev;
        t_data w_next;
        if (g == 0) begin : g_top
            assign w_prev = w_push_data;
        end else begin : g_mid
            assign w_prev = w_cell[g-1];
        end
        if (g == STACK_DEPTH - 1) begin : g_bot
            assign w_next = '0;
        end else begin : g_up
            assign w_next = w_cell[g+1];
        end
        rse_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl[g]),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_val  (w_cell[g])
        );
    end

    rse_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_lhs),
        .i_divisor  (w_rhs),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_tok.func;
            r_val  <= t_data'(i_tok.operand_value);
            r_last <= i_tok.last_token;
        end
        r_res    <= n_res;
        r_answer <= n_answer;
        r_status <= n_status;
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.answer = r_answer;
    assign o_res.status = r_status;

endmodule

`default_nettype wire

/* src/rse_checker.sv */
// Checker: port-level assertions for the RPN evaluator, bound to the top level.
`default_nettype none

module rse_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_tok_valid,
    input wire logic                 i_tok_ready,
    input wire logic                 i_res_valid,
    input wire logic                 i_res_ready,
    input wire logic [31:0]          i_res_answer,
    input wire rse_pkg::t_status     i_res_status
);
    import rse_pkg::*;

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_answer) && $stable(i_res_status))
        else $error("stalled result changed");

    // an error status carries a zero answer
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status != ST_OK) |-> (i_res_answer == '0))
        else $error("nonzero answer with error status");

    // one token at a time: the sequencer is busy right after taking one
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_valid && i_tok_ready |=> !i_tok_ready)
        else $error("token taken while previous one in flight");

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_tok_valid  (i_tok.valid),
    .i_tok_ready  (i_tok.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_answer (o_res.answer),
    .i_res_status (o_res.status)
);

`default_nettype wire

/* tb/rpn_stack_evaluator_tb.sv */
// Testbench for rpn_stack_evaluator: RPN token stimulus, answer prediction and checking.
import rse_pkg::*;

class rpn_answer_board;
    typedef struct packed {
        t_data   answer;
        t_status status;
    } t_rpn_answer;

    t_data       stack_mem[STACK_DEPTH];
    int          held;
    t_status     err_code;
    t_rpn_answer pending_answers[$];
    int          mismatches;

    function new();
        held       = 0;
        err_code   = ST_OK;
        mismatches = 0;
    endfunction

    function int pending();
        return pending_answers.size();
    endfunction

    // an empty stack pops as zero
    function t_data pop_operand();
        if (held == 0) return '0;
        held--;
        return stack_mem[held];
    endfunction

    function void push_operand(t_data v);
        if (held >= STACK_DEPTH) begin
            err_code = ST_OVERFLOW;
        end else begin
            stack_mem[held] = v;
            held++;
        end
    endfunction

    function void note_token(t_func f, t_data v, bit last);
        t_data       rhs;
        t_data       lhs;
        longint      quot;
        t_rpn_answer r;
        // once an error is latched, tokens do nothing until the last one
        if (err_code == ST_OK) begin
            if (f == FN_NUM) begin
                push_operand(v);
            end else if (f > FN_DIV) begin
                err_code = ST_INVALID;
            end else begin
                rhs = pop_operand();
                lhs = pop_operand();
                case (f)
                    FN_ADD: push_operand(lhs + rhs);
                    FN_SUB: push_operand(lhs - rhs);
                    FN_MUL: push_operand(lhs * rhs);
                    default: begin
                        if (rhs == '0) begin
                            err_code = ST_DIVZERO;
                        end else begin
                            // 64-bit so that most negative over minus one wraps cleanly
                            quot = longint'($signed(lhs)) / longint'($signed(rhs));
                            push_operand(t_data'(quot));
                        end
                    end
                endcase
            end
        end
        if (!last) return;
        r.answer = '0;
        r.status = err_code;
        if (r.status == ST_OK) begin
            if (held == 0) r.status = ST_EMPTY;
            else r.answer = stack_mem[held - 1];
        end
        pending_answers.push_back(r);
        held     = 0;
        err_code = ST_OK;
    endfunction

    function void check_answer(t_data answer, t_status status);
        t_rpn_answer exp_r;
        if (pending_answers.size() == 0) begin
            $error("unexpected result: answer %0d status %0d", $signed(answer), status);
            mismatches++;
            return;
        end
        exp_r = pending_answers.pop_front();
        if (answer !== exp_r.answer) begin
            $error("answer: expected %0d, got %0d", $signed(exp_r.answer), $signed(answer));
            mismatches++;
        end
        if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            mismatches++;
        end
    endfunction
endclass

module rpn_stack_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_func FN_INVALID5 = 3'd5;
    localparam t_func FN_INVALID6 = 3'd6;
    localparam t_func FN_INVALID7 = 3'd7;
    localparam t_data MAX_POS     = 32'h7FFF_FFFF;
    localparam t_data MIN_NEG     = 32'h8000_0000;
    localparam t_data MINUS_ONE   = 32'hFFFF_FFFF;
    localparam int    N_TOKENS    = 700;
    localparam int    TAIL_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;

    rse_tok_if tok_if ();
    rse_res_if res_if ();

    rpn_stack_evaluator i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tok  (tok_if.sink),
        .o_res  (res_if.source)
    );

    rpn_answer_board board;
    int              tokens_sent;
    bit              quiet;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    // result side: check accepted results, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_answer(res_if.answer, res_if.status);
        res_if.ready <= quiet || ($urandom_range(99) >= 34);
    end

    function automatic t_data pick_operand();
        case ($urandom_range(9))
            0: return MAX_POS;
            1: return MIN_NEG;
            2: return MINUS_ONE;
            3, 4, 5: return t_data'($urandom_range(20)) - t_data'(10);
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic send_token(t_func f, t_data v, bit last);
        while (!quiet && $urandom_range(99) < 34) begin
            tok_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tok_if.valid         <= 1'b1;
        tok_if.func          <= f;
        tok_if.operand_value <= v;
        tok_if.last_token    <= last;
        do @(posedge i_clk); while (!tok_if.ready);
        board.note_token(f, v, last);
        tokens_sent++;
    endtask

    task automatic wait_for_answers();
        tok_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // well-formed expression with random content; deep ones may overflow,
    // a few get a bad operator or are cut short
    task automatic send_expression();
        int    n_operands;
        int    pushed;
        int    depth;
        bit    deep;
        bit    last;
        t_func op;
        n_operands = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 8);
        deep       = (n_operands > 8) || ($urandom_range(3) == 0);
        pushed     = 0;
        depth      = 0;
        while (pushed < n_operands || depth > 1) begin
            if (depth >= 2 && (pushed == n_operands || (!deep && $urandom_range(1) == 1))) begin
                last = (pushed == n_operands && depth == 2);
                op   = t_func'($urandom_range(FN_ADD, FN_DIV));
                if ($urandom_range(39) == 0)
                    op = t_func'($urandom_range(FN_INVALID5, FN_INVALID7));
                depth--;
            end else begin
                last = (pushed + 1 == n_operands && depth == 0);
                op   = FN_NUM;
                pushed++;
                depth++;
            end
            if (!last && $urandom_range(59) == 0) begin
                send_token(op, pick_operand(), 1'b1);
                break;
            end
            send_token(op, pick_operand(), last);
        end
    endtask

    initial begin
        board       = new();
        tokens_sent = 0;
        quiet       = 1'b0;
        i_rst_n              <= 1'b0;
        tok_if.valid         <= 1'b0;
        tok_if.func          <= FN_NUM;
        tok_if.operand_value <= '0;
        tok_if.last_token    <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_token(FN_NUM, MAX_POS, 1'b1);
        send_token(FN_NUM, MIN_NEG, 1'b0);
        send_token(FN_NUM, MIN_NEG, 1'b0);
        send_token(FN_ADD, '0, 1'b1);
        send_token(FN_NUM, MIN_NEG, 1'b0);
        send_token(FN_NUM, t_data'(1), 1'b0);
        send_token(FN_SUB, '0, 1'b1);
        send_token(FN_NUM, MAX_POS, 1'b0);
        send_token(FN_NUM, MAX_POS, 1'b0);
        send_token(FN_MUL, MINUS_ONE, 1'b1);
        send_token(FN_NUM, t_data'(-7), 1'b0);
        send_token(FN_NUM, t_data'(2), 1'b0);
        send_token(FN_DIV, '0, 1'b1);
        // most negative over minus one
        send_token(FN_NUM, MIN_NEG, 1'b0);
        send_token(FN_NUM, MINUS_ONE, 1'b0);
        send_token(FN_DIV, '0, 1'b1);
        send_token(FN_NUM, t_data'(5), 1'b0);
        send_token(FN_NUM, '0, 1'b0);
        send_token(FN_DIV, '0, 1'b1);
        send_token(FN_INVALID5, '0, 1'b1);
        // first error wins over the later push
        send_token(FN_INVALID6, '0, 1'b0);
        send_token(FN_NUM, t_data'(1), 1'b1);
        send_token(FN_INVALID7, MINUS_ONE, 1'b1);
        // operator on an empty stack works on zeros
        send_token(FN_ADD, '0, 1'b1);
        wait_for_answers();

        while (tokens_sent < N_TOKENS) begin
            quiet = (tokens_sent >= 250 && tokens_sent < 400);
            if ($urandom_range(9) == 0)
                send_token(t_func'($urandom_range(7)), t_data'($urandom),
                           1'($urandom_range(1)));
            else
                send_expression();
            if ($urandom_range(24) == 0)
                wait_for_answers();
        end
        quiet = 1'b0;

        wait_for_answers();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
